### src/tccw_pkg.sv
// ---------------------------------------------------------------------------
// tccw_pkg: text console character writer definitions
// Character codes, request actions and the control group passed from the
// cursor unit to the top level.
// ---------------------------------------------------------------------------
package tccw_pkg;

    localparam logic [7:0] CODE_CR = 8'h0d;
    localparam logic [7:0] CODE_LF = 8'h0a;
    localparam logic [7:0] CODE_BS = 8'h08;
    localparam logic [7:0] BLANK   = 8'h20;

    localparam logic ACT_PUT  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef struct packed {
        logic wr_en;
        logic scroll;
    } t_put_ctrl;

endpackage

### src/tccw_in_if.sv
// ---------------------------------------------------------------------------
// tccw_in_if: request channel
// Valid/ready channel carrying one console request.
// ---------------------------------------------------------------------------
interface tccw_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [7:0]  char_code;
    logic [10:0] cell_index;

    modport source (output valid, action, char_code, cell_index, input ready);
    modport sink   (input valid, action, char_code, cell_index, output ready);
endinterface

### src/tccw_out_if.sv
// ---------------------------------------------------------------------------
// tccw_out_if: response channel
// Valid/ready channel carrying one console response.
// ---------------------------------------------------------------------------
interface tccw_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_char;
    logic [10:0] cursor_pos;
    logic        scrolled;

    modport source (output valid, read_char, cursor_pos, scrolled, input ready);
    modport sink   (input valid, read_char, cursor_pos, scrolled, output ready);
endinterface

### src/tccw_cursor.sv
// ---------------------------------------------------------------------------
// tccw_cursor: cursor update for put requests
// Decodes the character code, computes the store write and the next cursor
// and column, and flags a scroll when the cursor runs past the screen.
// ---------------------------------------------------------------------------
module tccw_cursor #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    localparam int CELLS  = COLUMNS * ROWS,
    localparam int CW     = $clog2(CELLS + COLUMNS),
    localparam int AW     = $clog2(CELLS),
    localparam int LW     = (COLUMNS > 1) ? $clog2(COLUMNS) : 1
) (
    input  logic [CW-1:0]       i_cursor,
    input  logic [LW-1:0]       i_col,
    input  logic [7:0]          i_code,
    output logic [CW-1:0]       o_cursor,
    output logic [LW-1:0]       o_col,
    output logic [AW-1:0]       o_wr_addr,
    output logic [7:0]          o_wr_data,
    output tccw_pkg::t_put_ctrl o_ctrl
);

    logic [CW-1:0] step;

    always_comb begin
        step      = i_cursor;
        o_col     = i_col;
        o_wr_addr = AW'(i_cursor);
        o_wr_data = i_code;
        o_ctrl    = '0;
        priority if (i_code == tccw_pkg::CODE_CR) begin
            step  = i_cursor - CW'(i_col);
            o_col = '0;
        end else if (i_code == tccw_pkg::CODE_LF) begin
            step = i_cursor + CW'(COLUMNS);
        end else if (i_code == tccw_pkg::CODE_BS) begin
            if (i_cursor != '0) begin
                step         = i_cursor - CW'(1);
                o_col        = (i_col == '0) ? LW'(COLUMNS - 1) : i_col - LW'(1);
                o_wr_addr    = AW'(step);
                o_wr_data    = tccw_pkg::BLANK;
                o_ctrl.wr_en = 1'b1;
            end
        end else begin
            step         = i_cursor + CW'(1);
            o_col        = (i_col == LW'(COLUMNS - 1)) ? '0 : i_col + LW'(1);
            o_ctrl.wr_en = 1'b1;
        end
        if (step >= CW'(CELLS)) begin
            o_cursor      = step - CW'(COLUMNS);
            o_ctrl.scroll = 1'b1;
        end else begin
            o_cursor = step;
        end
    end

endmodule

### src/text_console_char_writer_unit.sv
// ---------------------------------------------------------------------------
// text_console_char_writer_unit: text console character writer
// Character store of COLUMNS x ROWS cells in one synchronous memory, with a
// linear cursor; handles put and read requests and scrolls the screen.
//
//   channel  | dir | fields
//   i_req    | in  | action, char_code, cell_index
//   o_rsp    | out | read_char, cursor_pos, scrolled
//
// Put without scroll: the response register loads on accepting the request.
// Read: registered read port of the store, then response register.
// Put with scroll: one cell rewritten per cycle through the single read port.
// After reset a clearing pass writes zero to every cell, with i_req.ready low.
// A stalled response holds i_req.ready low.
// ---------------------------------------------------------------------------
module text_console_char_writer_unit #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tccw_in_if.sink     i_req,
    tccw_out_if.source  o_rsp
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int CW    = $clog2(CELLS + COLUMNS);
    localparam int AW    = $clog2(CELLS);
    localparam int LW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_SCROLL,
        S_DRAIN
    } t_state;

    t_state        r_state;
    logic [AW-1:0] r_clr;
    logic [CW-1:0] r_cursor;
    logic [LW-1:0] r_col;
    logic [CW-1:0] r_src;
    logic          r_wr_v;
    logic          r_wr_blank;
    logic [AW-1:0] r_wr_addr;
    logic          r_rd_zero;
    logic          r_out_valid;
    logic [7:0]    r_out_char;
    logic          r_out_scrolled;
    logic [7:0]    r_rd_data;

    logic [7:0]    mem [CELLS];

    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [7:0]    mem_wd;
    logic [AW-1:0] mem_ra;

    logic [CW-1:0]       n_cursor;
    logic [LW-1:0]       n_col;
    logic [AW-1:0]       put_addr;
    logic [7:0]          put_data;
    tccw_pkg::t_put_ctrl put_ctrl;

    logic accept;
    logic out_free;
    logic rsp_load;

    tccw_cursor #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_cursor (
        .i_cursor  (r_cursor),
        .i_col     (r_col),
        .i_code    (i_req.char_code),
        .o_cursor  (n_cursor),
        .o_col     (n_col),
        .o_wr_addr (put_addr),
        .o_wr_data (put_data),
        .o_ctrl    (put_ctrl)
    );

    assign out_free    = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE) && out_free;
    assign accept      = i_req.valid && i_req.ready;
    assign rsp_load    = (r_state == S_READ) || (r_state == S_DRAIN)
                      || (accept && (i_req.action == tccw_pkg::ACT_PUT) && !put_ctrl.scroll);

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.read_char  = r_out_char;
    assign o_rsp.cursor_pos = 11'(r_cursor);
    assign o_rsp.scrolled   = r_out_scrolled;

    always_comb begin
        mem_we = 1'b0;
        mem_wa = put_addr;
        mem_wd = put_data;
        mem_ra = AW'(i_req.cell_index);
        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr;
                mem_wd = '0;
            end
            S_IDLE: begin
                mem_we = accept && (i_req.action == tccw_pkg::ACT_PUT) && put_ctrl.wr_en;
            end
            S_READ: begin
                mem_we = 1'b0;
            end
            S_SCROLL, S_DRAIN: begin
                mem_we = r_wr_v;
                mem_wa = r_wr_addr;
                mem_wd = r_wr_blank ? tccw_pkg::BLANK : r_rd_data;
                mem_ra = AW'(r_src);
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_cursor    <= '0;
            r_col       <= '0;
            r_wr_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (rsp_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(CELLS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        if (i_req.action == tccw_pkg::ACT_READ) begin
                            r_rd_zero <= !(32'(i_req.cell_index) < CELLS);
                            r_state   <= S_READ;
                        end else begin
                            r_cursor <= n_cursor;
                            r_col    <= n_col;
                            if (put_ctrl.scroll) begin
                                r_src   <= CW'(COLUMNS);
                                r_wr_v  <= 1'b0;
                                r_state <= S_SCROLL;
                            end else begin
                                r_out_char     <= '0;
                                r_out_scrolled <= 1'b0;
                            end
                        end
                    end
                end
                S_READ: begin
                    r_out_char     <= r_rd_zero ? 8'd0 : r_rd_data;
                    r_out_scrolled <= 1'b0;
                    r_state        <= S_IDLE;
                end
                S_SCROLL: begin
                    r_wr_v     <= 1'b1;
                    r_wr_addr  <= AW'(r_src - CW'(COLUMNS));
                    r_wr_blank <= (r_src >= CW'(CELLS));
                    r_src      <= r_src + CW'(1);
                    if (r_src == CW'(CELLS + COLUMNS - 1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_wr_v         <= 1'b0;
                    r_out_char     <= '0;
                    r_out_scrolled <= 1'b1;
                    r_state        <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
